FILE: hdl/tshf_pkg.sv
// Shared types and constants for the turn signal and hazard flasher.
// Used by tshf_step, turn_signal_hazard_flasher and the testbench; depends on nothing else.
package tshf_pkg;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0] HOLD_RESET = 16'd1000;
    localparam logic [CNT_W-1:0] BLINK_RESET = 16'd300;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_PERIOD = 8'd1;

    // Event codes reported with each tick.
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_LEFT_ON    = 3'd1,
        EV_LEFT_OFF   = 3'd2,
        EV_RIGHT_ON   = 3'd3,
        EV_RIGHT_OFF  = 3'd4,
        EV_HAZARD_ON  = 3'd5,
        EV_HAZARD_OFF = 3'd6
    } event_t;

    // Complete control state of the flasher.
    typedef struct packed {
        logic             left_active;
        logic             right_active;
        logic             hazard_active;
        logic             left_done;
        logic             right_done;
        logic             both_done;
        logic [CNT_W-1:0] left_hold_count;
        logic [CNT_W-1:0] right_hold_count;
        logic [CNT_W-1:0] blink_count;
        logic             blink_phase;
        logic [1:0]       lamp_levels;
    } state_t;

endpackage

FILE: hdl/tshf_step.sv
// Next-state logic of the flasher for one tick: button handling and blink phase.
// Depends on tshf_pkg for the state type, event codes and counter limits.
module tshf_step (
    input  tshf_pkg::state_t              state_i,
    input  logic                          left_pressed,
    input  logic                          right_pressed,
    input  logic [tshf_pkg::CNT_W-1:0]    hold_ticks,
    input  logic [tshf_pkg::CNT_W-1:0]    blink_half_period,
    output tshf_pkg::state_t              state_o,
    output tshf_pkg::event_t              event_code
);

    always_comb begin
        tshf_pkg::state_t s;
        tshf_pkg::event_t ev;
        logic             llong;
        logic             rlong;

        s  = state_i;
        ev = tshf_pkg::EV_NONE;

        // Hold counters saturate while pressed and clear on release.
        if (!left_pressed) begin
            s.left_hold_count = '0;
        end else if (s.left_hold_count != tshf_pkg::CNT_MAX) begin
            s.left_hold_count = s.left_hold_count + 1'b1;
        end
        if (!right_pressed) begin
            s.right_hold_count = '0;
        end else if (s.right_hold_count != tshf_pkg::CNT_MAX) begin
            s.right_hold_count = s.right_hold_count + 1'b1;
        end

        llong = left_pressed && ((s.left_hold_count > hold_ticks) ||
                                 (s.left_hold_count == tshf_pkg::CNT_MAX));
        rlong = right_pressed && ((s.right_hold_count > hold_ticks) ||
                                  (s.right_hold_count == tshf_pkg::CNT_MAX));

        // Left button alone toggles the left indicator.
        if (left_pressed) begin
            if (llong && !s.left_done && !s.hazard_active && !right_pressed) begin
                if (!s.left_active) begin
                    s.left_active  = 1'b1;
                    s.right_active = 1'b0;
                    ev = tshf_pkg::EV_LEFT_ON;
                end else begin
                    s.left_active = 1'b0;
                    ev = tshf_pkg::EV_LEFT_OFF;
                end
                s.left_done = 1'b1;
            end
        end else begin
            s.left_done = 1'b0;
        end

        // Right button alone toggles the right indicator.
        if (right_pressed) begin
            if (rlong && !s.right_done && !s.hazard_active && !left_pressed) begin
                if (!s.right_active) begin
                    s.right_active = 1'b1;
                    s.left_active  = 1'b0;
                    ev = tshf_pkg::EV_RIGHT_ON;
                end else begin
                    s.right_active = 1'b0;
                    ev = tshf_pkg::EV_RIGHT_OFF;
                end
                s.right_done = 1'b1;
            end
        end else begin
            s.right_done = 1'b0;
        end

        // Both buttons held long enter hazard mode.
        if (left_pressed && right_pressed) begin
            if (llong && rlong && !s.both_done) begin
                s.hazard_active = 1'b1;
                s.left_active   = 1'b0;
                s.right_active  = 1'b0;
                s.both_done     = 1'b1;
                s.left_done     = 1'b1;
                s.right_done    = 1'b1;
                ev = tshf_pkg::EV_HAZARD_ON;
            end
        end else begin
            s.both_done = 1'b0;
        end

        // An unhandled long press leaves hazard mode.
        if (s.hazard_active && ((llong && !s.left_done) || (rlong && !s.right_done))) begin
            s.hazard_active = 1'b0;
            if (left_pressed) begin
                s.left_done = 1'b1;
            end
            if (right_pressed) begin
                s.right_done = 1'b1;
            end
            ev = tshf_pkg::EV_HAZARD_OFF;
        end

        // Blink phase and the lamp levels latched at each toggle.
        if (s.blink_count != tshf_pkg::CNT_MAX) begin
            s.blink_count = s.blink_count + 1'b1;
        end
        if (s.blink_count >= blink_half_period) begin
            s.blink_count = '0;
            s.blink_phase = !s.blink_phase;
            if (s.hazard_active) begin
                s.lamp_levels = {s.blink_phase, s.blink_phase};
            end else begin
                s.lamp_levels = {s.right_active & s.blink_phase,
                                 s.left_active & s.blink_phase};
            end
        end

        state_o    = s;
        event_code = ev;
    end

endmodule

FILE: hdl/turn_signal_hazard_flasher.sv
// Top level of the turn signal and hazard flasher: handshakes, state and result register.
// Depends on tshf_pkg and tshf_step.
//
// Usage: each word on the s_ channel is one millisecond tick carrying the left
// and right button levels. For every accepted word the block returns exactly
// one word on the m_ channel with the two lamp levels and an event code.
// The tick is processed by the step logic in the cycle it is accepted; the
// state registers and the result register load at that edge, so the result
// is offered in the cycle after acceptance. One word is accepted per cycle for
// as long as the receiver takes results; the single result register sets
// that rate.
// When the receiver stalls, the result register holds its word and s_tready
// drops until it is taken; no tick is lost or repeated.
// The configuration channel writes hold_ticks (index 0) and
// blink_half_period (index 1); it is always ready, and writes to other
// indexes are ignored. The user is to write configuration only while the
// block is idle; the block does not enforce this. Reset (aresetn low,
// synchronous) clears all modes, counters, the blink phase and the lamps,
// restores the register defaults of 1000 and 300, and empties the result register.
module turn_signal_hazard_flasher (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Tick words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [0] left_pressed, [1] right_pressed
    // Result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,    // [0] left_lamp, [1] right_lamp,
                                                        // [4:2] event_code
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tshf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tshf_pkg::CNT_W-1:0]      cfg_data
);

    tshf_pkg::state_t             state_reg;
    tshf_pkg::state_t             state_next;
    tshf_pkg::event_t             event_next;
    logic [tshf_pkg::CNT_W-1:0]   hold_ticks_reg;
    logic [tshf_pkg::CNT_W-1:0]   blink_half_period_reg;
    logic                         m_tvalid_reg;
    logic [7:0]                   m_tdata_reg;
    logic                         s_accept;

    // A new tick is taken whenever the result register is free or being emptied.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    tshf_step u_step (
        .state_i           (state_reg),
        .left_pressed      (s_tdata[0]),
        .right_pressed     (s_tdata[1]),
        .hold_ticks        (hold_ticks_reg),
        .blink_half_period (blink_half_period_reg),
        .state_o           (state_next),
        .event_code        (event_next)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg        <= tshf_pkg::HOLD_RESET;
            blink_half_period_reg <= tshf_pkg::BLINK_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == tshf_pkg::REG_HOLD_TICKS) begin
                hold_ticks_reg <= cfg_data;
            end else if (cfg_index == tshf_pkg::REG_BLINK_HALF_PERIOD) begin
                blink_half_period_reg <= cfg_data;
            end
        end
    end

    // Flasher state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {3'b000, event_next, state_next.lamp_levels};
        end
    end

`ifndef SYNTHESIS
    // Every accepted tick leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted tick produced no result");

    // The indicators are mutually exclusive.
    a_one_indicator: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.left_active && state_reg.right_active))
        else $error("both indicators active");

    // Hazard mode clears both indicators.
    a_hazard_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.hazard_active |-> !state_reg.left_active && !state_reg.right_active)
        else $error("indicator active during hazard");

    // Reported event codes stay within the defined set.
    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:2] != 3'd7)
        else $error("undefined event code");

    // Lamps only change when the blink counter has just wrapped.
    a_lamps_at_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.lamp_levels != $past(state_reg.lamp_levels)) |->
            state_reg.blink_count == '0)
        else $error("lamp levels changed away from a phase toggle");
`endif

endmodule

FILE: tb/turn_signal_hazard_flasher_tb.sv
// Self-checking testbench for turn_signal_hazard_flasher: directed ticks, then random button
// sequences under several register settings; each result word is checked against the script or a predictor.
// Depends on tshf_pkg and the turn_signal_hazard_flasher RTL.
module turn_signal_hazard_flasher_tb;

    localparam int STALL_LIMIT = 5000;
    // An index that names no register; writes to it must change nothing.
    localparam logic [tshf_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;

    // One result word as it sits in m_tdata, lowest bit last in the list.
    typedef struct packed {
        logic [2:0]       pad;
        tshf_pkg::event_t ev;
        logic             right_lamp;
        logic             left_lamp;
    } lamp_word_t;

    // Per offered tick: whether the expected word is written in the script.
    typedef struct packed {
        bit         typed;
        lamp_word_t want;
    } known_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                           kind;
        logic                                lp;
        logic                                rp;
        logic [tshf_pkg::CFG_IDX_W-1:0]      idx;
        logic [tshf_pkg::CNT_W-1:0]          val;
        bit                                  typed;
        lamp_word_t                          want;
    } script_row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [7:0]                          s_tdata;    // [0] left_pressed, [1] right_pressed
    logic                                m_tvalid;
    logic                                m_tready;
    logic [7:0]                          m_tdata;    // [0] left_lamp, [1] right_lamp,
                                                     // [4:2] event_code
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [tshf_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [tshf_pkg::CNT_W-1:0]          cfg_data;

    // Predicted flasher state and register copies.
    logic                       p_left_on, p_right_on, p_hazard;
    logic                       p_left_done, p_right_done, p_both_done;
    logic [tshf_pkg::CNT_W-1:0] p_left_hold, p_right_hold, p_blink_cnt;
    logic                       p_blink_phase;
    logic [1:0]                 p_lamps;
    logic [tshf_pkg::CNT_W-1:0] hold_limit, blink_period;

    lamp_word_t    due_q[$];
    known_t        known_q[$];
    script_row_t   script[$];
    int            failures = 0;
    int            idle_cycles = 0;
    int            ticks_sent = 0;
    bit            calm_mode = 1'b0;
    int            cur_hold = 1;

    turn_signal_hazard_flasher u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Advance the predicted state by one tick and return the word it should produce.
    function automatic lamp_word_t step_flasher(input logic lp, input logic rp);
        lamp_word_t       res;
        logic             l_long, r_long;
        tshf_pkg::event_t ev;
        ev = tshf_pkg::EV_NONE;
        p_left_hold = !lp ? '0 : ((p_left_hold != tshf_pkg::CNT_MAX) ? p_left_hold + 1'b1
                                                                     : p_left_hold);
        p_right_hold = !rp ? '0 : ((p_right_hold != tshf_pkg::CNT_MAX) ? p_right_hold + 1'b1
                                                                       : p_right_hold);
        l_long = lp && (p_left_hold > hold_limit || p_left_hold == tshf_pkg::CNT_MAX);
        r_long = rp && (p_right_hold > hold_limit || p_right_hold == tshf_pkg::CNT_MAX);

        // A single long press toggles its own indicator.
        if (lp) begin
            if (l_long && !p_left_done && !p_hazard && !rp) begin
                if (!p_left_on) begin
                    p_left_on = 1'b1;
                    p_right_on = 1'b0;
                    ev = tshf_pkg::EV_LEFT_ON;
                end else begin
                    p_left_on = 1'b0;
                    ev = tshf_pkg::EV_LEFT_OFF;
                end
                p_left_done = 1'b1;
            end
        end else begin
            p_left_done = 1'b0;
        end
        if (rp) begin
            if (r_long && !p_right_done && !p_hazard && !lp) begin
                if (!p_right_on) begin
                    p_right_on = 1'b1;
                    p_left_on = 1'b0;
                    ev = tshf_pkg::EV_RIGHT_ON;
                end else begin
                    p_right_on = 1'b0;
                    ev = tshf_pkg::EV_RIGHT_OFF;
                end
                p_right_done = 1'b1;
            end
        end else begin
            p_right_done = 1'b0;
        end

        // Both held long enough enter hazard and mark both buttons handled.
        if (lp && rp) begin
            if (l_long && r_long && !p_both_done) begin
                p_hazard = 1'b1;
                p_left_on = 1'b0;
                p_right_on = 1'b0;
                p_both_done = 1'b1;
                p_left_done = 1'b1;
                p_right_done = 1'b1;
                ev = tshf_pkg::EV_HAZARD_ON;
            end
        end else begin
            p_both_done = 1'b0;
        end

        // An unhandled long press leaves hazard; the pressed buttons count as handled.
        if (p_hazard && ((l_long && !p_left_done) || (r_long && !p_right_done))) begin
            p_hazard = 1'b0;
            if (lp) p_left_done = 1'b1;
            if (rp) p_right_done = 1'b1;
            ev = tshf_pkg::EV_HAZARD_OFF;
        end

        // The lamps follow the modes only when the blink phase toggles.
        if (p_blink_cnt != tshf_pkg::CNT_MAX) p_blink_cnt = p_blink_cnt + 1'b1;
        if (p_blink_cnt >= blink_period) begin
            p_blink_cnt = '0;
            p_blink_phase = !p_blink_phase;
            if (p_hazard)
                p_lamps = {2{p_blink_phase}};
            else
                p_lamps = {p_right_on & p_blink_phase, p_left_on & p_blink_phase};
        end

        res = '0;
        res.left_lamp = p_lamps[0];
        res.right_lamp = p_lamps[1];
        res.ev = ev;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Watch all three channels: predict on accepted ticks, check accepted results.
    always @(posedge aclk) begin
        lamp_word_t got;
        lamp_word_t want;
        known_t     k;
        if (!aresetn) begin
            hold_limit = tshf_pkg::HOLD_RESET;
            blink_period = tshf_pkg::BLINK_RESET;
            {p_left_on, p_right_on, p_hazard} = '0;
            {p_left_done, p_right_done, p_both_done} = '0;
            p_left_hold = '0;
            p_right_hold = '0;
            p_blink_cnt = '0;
            p_blink_phase = 1'b0;
            p_lamps = '0;
            idle_cycles = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_q.size() == 0) begin
                    $error("result word arrived with no tick waiting");
                    failures++;
                end else begin
                    want = due_q.pop_front();
                    got = lamp_word_t'(m_tdata);
                    check_field("left_lamp", 3'(want.left_lamp), 3'(got.left_lamp));
                    check_field("right_lamp", 3'(want.right_lamp), 3'(got.right_lamp));
                    check_field("event_code", want.ev, got.ev);
                    check_field("tdata padding", want.pad, got.pad);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tshf_pkg::REG_HOLD_TICKS)
                    hold_limit = cfg_data;
                else if (cfg_index == tshf_pkg::REG_BLINK_HALF_PERIOD)
                    blink_period = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                k = known_q.pop_front();
                want = step_flasher(s_tdata[0], s_tdata[1]);
                if (k.typed) want = k.want;
                due_q.push_back(want);
            end

            // Give up if no channel moves a word for too long.
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: ready for a random run of cycles, then, unless in calm mode, mostly short stalls, a few long.
    initial begin
        int run_len;
        int stall_len;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            run_len = $urandom_range(1, 24);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if (!calm_mode) begin
                stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 60);
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one tick word and return at the edge that accepts it.
    task automatic press_tick(input logic lp, input logic rp, input bit typed,
                              input lamp_word_t want);
        int     gap;
        known_t k;
        cfg_valid <= 1'b0;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        k.typed = typed;
        k.want = want;
        known_q.push_back(k);
        ticks_sent++;
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, rp, lp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic press_run(input logic lp, input logic rp, input int count);
        repeat (count) press_tick(lp, rp, 1'b0, '0);
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (due_q.size() != 0) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the next tick or wait_idle lowers it.
    task automatic write_reg(input logic [tshf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tshf_pkg::CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure(input int hold, input int blink);
        wait_idle();
        write_reg(tshf_pkg::REG_HOLD_TICKS, hold[tshf_pkg::CNT_W-1:0]);
        write_reg(tshf_pkg::REG_BLINK_HALF_PERIOD, blink[tshf_pkg::CNT_W-1:0]);
        cur_hold = hold;
    endtask

    // Mostly well-formed presses around the hold length, with some noise between.
    task automatic random_ticks(input int n);
        int target;
        int h_eff;
        int len;
        int kind;
        target = ticks_sent + n;
        h_eff = (cur_hold > 20) ? 20 : cur_hold;
        while (ticks_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                kind = $urandom_range(0, 3);
                len = ($urandom_range(0, 4) != 0) ? h_eff + $urandom_range(1, 3)
                                                  : $urandom_range(1, h_eff + 1);
                case (kind)
                    0: press_run(1'b1, 1'b0, len);
                    1: press_run(1'b0, 1'b1, len);
                    2: press_run(1'b1, 1'b1, len);
                    default: begin
                        // One button leads the other by a tick or two.
                        if ($urandom_range(0, 1))
                            press_run(1'b1, 1'b0, $urandom_range(1, 2));
                        else
                            press_run(1'b0, 1'b1, $urandom_range(1, 2));
                        press_run(1'b1, 1'b1, len);
                    end
                endcase
                press_run(1'b0, 1'b0, $urandom_range(1, 3));
            end else begin
                repeat ($urandom_range(1, 6))
                    press_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end
    endtask

    function automatic void add_tick(input logic lp, input logic rp);
        script_row_t r;
        r = '{kind: ROW_TICK, lp: lp, rp: rp, idx: '0, val: '0, typed: 1'b0, want: '0};
        script.push_back(r);
    endfunction

    // A tick whose word is known outright: lamps still dark, only the event matters.
    function automatic void add_seen(input logic lp, input logic rp,
                                     input tshf_pkg::event_t ev);
        script_row_t r;
        r = '{kind: ROW_TICK, lp: lp, rp: rp, idx: '0, val: '0, typed: 1'b1, want: '0};
        r.want.ev = ev;
        script.push_back(r);
    endfunction

    function automatic void add_write(input logic [tshf_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [tshf_pkg::CNT_W-1:0] val);
        script_row_t r;
        r = '{kind: ROW_WRITE, lp: 1'b0, rp: 1'b0, idx: idx, val: val, typed: 1'b0, want: '0};
        script.push_back(r);
    endfunction

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;

        // Directed script. The blink period stays at its default throughout the
        // written-out rows, so the lamps remain dark and only events change.
        add_seen(1'b0, 1'b0, tshf_pkg::EV_NONE);
        add_write(tshf_pkg::REG_HOLD_TICKS, 16'd0);        // a press counts from its first tick
        add_seen(1'b1, 1'b0, tshf_pkg::EV_LEFT_ON);
        add_seen(1'b1, 1'b0, tshf_pkg::EV_NONE);
        add_seen(1'b0, 1'b0, tshf_pkg::EV_NONE);
        add_seen(1'b0, 1'b1, tshf_pkg::EV_RIGHT_ON);
        add_seen(1'b1, 1'b1, tshf_pkg::EV_HAZARD_ON);
        add_seen(1'b1, 1'b1, tshf_pkg::EV_NONE);
        add_seen(1'b0, 1'b0, tshf_pkg::EV_NONE);
        add_seen(1'b1, 1'b0, tshf_pkg::EV_HAZARD_OFF);
        add_seen(1'b1, 1'b1, tshf_pkg::EV_HAZARD_ON);      // left still held from leaving hazard
        add_seen(1'b0, 1'b0, tshf_pkg::EV_NONE);
        add_seen(1'b0, 1'b1, tshf_pkg::EV_HAZARD_OFF);
        add_seen(1'b0, 1'b1, tshf_pkg::EV_NONE);
        add_seen(1'b0, 1'b0, tshf_pkg::EV_NONE);
        add_seen(1'b0, 1'b1, tshf_pkg::EV_RIGHT_ON);
        add_seen(1'b0, 1'b0, tshf_pkg::EV_NONE);
        add_seen(1'b0, 1'b1, tshf_pkg::EV_RIGHT_OFF);
        add_seen(1'b1, 1'b0, tshf_pkg::EV_LEFT_ON);
        add_seen(1'b0, 1'b0, tshf_pkg::EV_NONE);
        add_seen(1'b1, 1'b0, tshf_pkg::EV_LEFT_OFF);
        add_write(tshf_pkg::REG_BLINK_HALF_PERIOD, 16'd0); // phase toggles on every tick
        add_tick(1'b1, 1'b1);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b0);
        add_tick(1'b0, 1'b0);
        add_write(REG_SPARE, 16'hFFFF);                    // unused index must be ignored
        add_tick(1'b0, 1'b1);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(script[i].idx, script[i].val);
            end else begin
                press_tick(script[i].lp, script[i].rp, script[i].typed, script[i].want);
            end
        end

        // Random phases under several register settings, some without any idling.
        configure(1, 1);
        random_ticks(90);
        calm_mode = 1'b1;
        configure(2, 3);
        random_ticks(90);
        calm_mode = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            configure($urandom_range(1, 6), $urandom_range(1, 12));
            calm_mode = ph[0];
            random_ticks(90);
        end
        calm_mode = 1'b0;
        configure(12, 65535);
        random_ticks(90);
        configure(4, 2);
        random_ticks(90);

        wait_idle();
        repeat (4) @(posedge aclk);
        if (due_q.size() != 0) begin
            $error("%0d expected words never arrived", due_q.size());
            failures++;
        end
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
